// ----- rtl/cmpl_pkg.sv -----
// ----------------------------------------------------------------------------
// cmpl_pkg
// shared types and constants for the piecewise-linear colour map
// ----------------------------------------------------------------------------
package cmpl_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int PosW = 32;
  localparam int ColW = 18;
  localparam int OutW = 17;
  localparam int TW = 17;
  localparam int DivSteps = 17;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_SMP_ENDS,
    ST_SMP_MAP,
    ST_SMP_SEARCH,
    ST_SMP_SEG,
    ST_SMP_DIV,
    ST_SMP_MUL,
    ST_SMP_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic ins_load;
    logic ins_shift;
    logic ins_write;
    logic smp_load;
    logic smp_ends;
    logic smp_map;
    logic smp_search;
    logic smp_seg;
    logic div_step;
    logic smp_mul;
    logic smp_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ins_done;
    logic search_done;
    logic div_done;
    logic [CntW-1:0] count;
  } status_t;

endpackage

// ----- rtl/cmpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmpl_ctrl
// sequencer for insert, clear and sample items
// ----------------------------------------------------------------------------
module cmpl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  cmpl_pkg::status_t  status,
  output cmpl_pkg::cmd_t     cmd,
  output logic               busy
);
  import cmpl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_CLEAR: cmd.clear = 1'b1;
            OP_INSERT: begin
              if (!status.full) begin
                cmd.ins_load = 1'b1;
                state_next = ST_INS_SHIFT;
              end
            end
            OP_SAMPLE: begin
              cmd.smp_load = 1'b1;
              state_next = ST_SMP_ENDS;
            end
            default: ;
          endcase
        end
      end
      ST_INS_SHIFT: begin
        if (status.ins_done) state_next = ST_INS_WRITE;
        else cmd.ins_shift = 1'b1;
      end
      ST_INS_WRITE: begin
        cmd.ins_write = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SMP_ENDS: begin
        if (status.count < CntW'(2)) begin
          state_next = ST_SMP_OUT;
        end else begin
          cmd.smp_ends = 1'b1;
          state_next = ST_SMP_MAP;
        end
      end
      ST_SMP_MAP: begin
        cmd.smp_map = 1'b1;
        state_next = ST_SMP_SEARCH;
      end
      ST_SMP_SEARCH: begin
        if (status.search_done) state_next = ST_SMP_SEG;
        else cmd.smp_search = 1'b1;
      end
      ST_SMP_SEG: begin
        cmd.smp_seg = 1'b1;
        state_next = ST_SMP_DIV;
      end
      ST_SMP_DIV: begin
        if (status.div_done) state_next = ST_SMP_MUL;
        else cmd.div_step = 1'b1;
      end
      ST_SMP_MUL: begin
        cmd.smp_mul = 1'b1;
        state_next = ST_SMP_OUT;
      end
      ST_SMP_OUT: begin
        cmd.smp_out = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/cmpl_dp.sv -----
// ----------------------------------------------------------------------------
// cmpl_dp
// point table, segment search, serial divider and blend
// ----------------------------------------------------------------------------
module cmpl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cmpl_pkg::cmd_t                cmd,
  input  logic                          reverse_mode,
  input  logic [cmpl_pkg::TW-1:0]       sample_t,
  input  logic signed [cmpl_pkg::PosW-1:0] point_position,
  input  logic signed [cmpl_pkg::ColW-1:0] point_red,
  input  logic signed [cmpl_pkg::ColW-1:0] point_green,
  input  logic signed [cmpl_pkg::ColW-1:0] point_blue,
  output cmpl_pkg::status_t             status,
  output logic                          done,
  output logic [cmpl_pkg::OutW-1:0]     out_red,
  output logic [cmpl_pkg::OutW-1:0]     out_green,
  output logic [cmpl_pkg::OutW-1:0]     out_blue
);
  import cmpl_pkg::*;

  localparam logic [TW-1:0] One = TW'(65536);

  logic signed [PosW-1:0] pos_mem [MaxPoints];
  logic signed [ColW-1:0] red_mem [MaxPoints];
  logic signed [ColW-1:0] grn_mem [MaxPoints];
  logic signed [ColW-1:0] blu_mem [MaxPoints];
  logic [CntW-1:0] count;

  logic signed [PosW-1:0] n_pos;
  logic signed [ColW-1:0] n_r, n_g, n_b;
  logic [CntW-1:0] k;
  logic [TW-1:0] t;

  logic signed [PosW:0] lo, hi, mapped, p1, p2;
  logic signed [ColW-1:0] c1 [3];
  logic signed [ColW-1:0] c2 [3];
  logic [PosW:0] num, den;
  logic [4:0] div_cnt;
  logic [TW-1:0] local_f;
  logic signed [ColW+TW+2:0] acc [3];
  logic [OutW-1:0] res [3];

  logic [IdxW-1:0] km1;
  logic [IdxW-1:0] kidx;
  logic [IdxW-1:0] kp1;
  assign km1 = IdxW'(k - CntW'(1));
  assign kidx = k[IdxW-1:0];
  assign kp1 = IdxW'(k + CntW'(1));

  assign p1 = (PosW+1)'(pos_mem[kidx]);
  assign p2 = (PosW+1)'(pos_mem[kp1]);

  assign status.full = (count == CntW'(MaxPoints));
  assign status.count = count;
  assign status.ins_done = (k == '0) || !(pos_mem[km1] > n_pos);
  assign status.search_done = (k + CntW'(1) >= count - CntW'(1)) ||
                              (mapped <= p2);
  assign status.div_done = (div_cnt == 5'(DivSteps));

  logic [PosW:0] span_mul_src;
  logic [PosW+TW:0] span_prod;
  assign span_mul_src = PosW'(0) + (hi - lo);
  assign span_prod = span_mul_src * t;

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.clear) count <= '0;
    else if (cmd.ins_write) count <= count + CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_load) begin
      n_pos <= point_position; n_r <= point_red; n_g <= point_green; n_b <= point_blue;
      k <= count;
    end
    if (cmd.ins_shift) begin
      pos_mem[kidx] <= pos_mem[km1];
      red_mem[kidx] <= red_mem[km1];
      grn_mem[kidx] <= grn_mem[km1];
      blu_mem[kidx] <= blu_mem[km1];
      k <= k - CntW'(1);
    end
    if (cmd.ins_write) begin
      pos_mem[kidx] <= n_pos; red_mem[kidx] <= n_r;
      grn_mem[kidx] <= n_g; blu_mem[kidx] <= n_b;
    end
    if (cmd.smp_load) begin
      if (reverse_mode) t <= One - ((sample_t > One) ? One : sample_t);
      else t <= (sample_t > One) ? One : sample_t;
    end
    if (cmd.smp_ends) begin
      lo <= (PosW+1)'(pos_mem[0]);
      hi <= (PosW+1)'(pos_mem[IdxW'(count - CntW'(1))]);
    end
    if (cmd.smp_map) begin
      mapped <= lo + (PosW+1)'(span_prod >> 16);
      k <= '0;
    end
    if (cmd.smp_search) k <= k + CntW'(1);
    if (cmd.smp_seg) begin
      den <= (p2 > p1) ? (PosW+1)'(p2 - p1) : '0;
      num <= (mapped > p1) ? (PosW+1)'(mapped - p1) : '0;
      c1[0] <= red_mem[kidx]; c1[1] <= grn_mem[kidx]; c1[2] <= blu_mem[kidx];
      c2[0] <= red_mem[kp1];
      c2[1] <= grn_mem[kp1];
      c2[2] <= blu_mem[kp1];
    end
    if (cmd.smp_mul) begin
      for (int j = 0; j < 3; j++) begin
        acc[j] <= (ColW+TW+3)'(c1[j]) * (ColW+TW+3)'(65536) +
                  (ColW+TW+3)'($signed({1'b0, local_f})) * (ColW+TW+3)'(c2[j] - c1[j]);
      end
    end
  end

  // restoring divider: num * 65536 / den, clamped to one
  logic [PosW+1:0] drem;
  logic [PosW+1:0] drem_sh;
  assign drem_sh = {drem[PosW:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.smp_seg) begin
      div_cnt <= '0;
      local_f <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == '0) begin
        drem <= {1'b0, num};
        if (den != '0 && num >= den) local_f <= One;
        else local_f <= '0;
      end else if (den != '0 && num < den) begin
        // 16 fraction bits, one per cycle
        if (drem_sh >= {1'b0, den}) begin
          drem <= drem_sh - {1'b0, den};
          local_f <= {local_f[TW-2:0], 1'b1};
        end else begin
          drem <= drem_sh;
          local_f <= {local_f[TW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (acc[j] <= 0) res[j] = '0;
      else if (acc[j] >= (ColW+TW+3)'(64'sd4294967296)) res[j] = One;
      else res[j] = OutW'(acc[j] >>> 16);
    end
  end

  function automatic logic [OutW-1:0] clampc(logic signed [ColW-1:0] c);
    if (c < 0) return '0;
    if (c > $signed(ColW'(65536))) return One;
    return OutW'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.smp_out;
    if (cmd.smp_out) begin
      if (count == '0) begin
        out_red <= '0; out_green <= '0; out_blue <= '0;
      end else if (count == CntW'(1)) begin
        out_red <= clampc(red_mem[0]);
        out_green <= clampc(grn_mem[0]);
        out_blue <= clampc(blu_mem[0]);
      end else begin
        out_red <= res[0]; out_green <= res[1]; out_blue <= res[2];
      end
    end
  end

endmodule

// ----- rtl/colormap_piecewise_linear.sv -----
// ----------------------------------------------------------------------------
// colormap_piecewise_linear
// piecewise-linear colour map over a sorted table of up to 16 points
// ----------------------------------------------------------------------------
// usage: raise start with opcode and operands while busy is low; the beat is
// taken at that edge. clear takes effect at once and leaves busy low. insert
// walks larger points up one slot a cycle, then writes the new point; a full
// table drops the beat at once.
// sample: setup (end points, mapped position), segment search, segment load,
// divider (one quotient bit a cycle), blend and output; result in the cycle
// after the last busy cycle. an empty or single point table skips to output.
// the next beat may be taken in the cycle that carries the result.
// the result appears on out_red/out_green/out_blue with valid high for one
// cycle; the receiver cannot stall it. reverse_mode is written on the
// cfg channel (cfg_valid/cfg_ready, cfg_data); the user must do so only
// while idle, as the block itself does not enforce it.
// reset empties the table and clears reverse_mode; point storage is not
// cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module colormap_piecewise_linear (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [16:0] sample_t,
  input  logic signed [31:0] point_position,
  input  logic signed [17:0] point_red,
  input  logic signed [17:0] point_green,
  input  logic signed [17:0] point_blue,
  output logic        valid,
  output logic [16:0] out_red,
  output logic [16:0] out_green,
  output logic [16:0] out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import cmpl_pkg::*;

  cmd_t cmd;
  status_t status;
  logic reverse_mode;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) reverse_mode <= 1'b0;
    else if (cfg_valid && cfg_ready) reverse_mode <= cfg_data;
  end

  cmpl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .status(status), .cmd(cmd), .busy(busy)
  );

  cmpl_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .reverse_mode(reverse_mode),
    .sample_t(sample_t), .point_position(point_position),
    .point_red(point_red), .point_green(point_green), .point_blue(point_blue),
    .status(status), .done(valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

endmodule

// ----- rtl/cmpl_checker.sv -----
// ----------------------------------------------------------------------------
// cmpl_checker
// port-level checks on the colour map
// ----------------------------------------------------------------------------
module cmpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        valid,
  input logic [16:0] out_red,
  input logic [16:0] out_green,
  input logic [16:0] out_blue
);
  a_red: assert property (@(posedge clk) disable iff (rst)
    valid |-> out_red <= 17'd65536) else $error("red out of range");
  a_grn: assert property (@(posedge clk) disable iff (rst)
    valid |-> out_green <= 17'd65536) else $error("green out of range");
  a_blu: assert property (@(posedge clk) disable iff (rst)
    valid |-> out_blue <= 17'd65536) else $error("blue out of range");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result beat longer than a cycle");
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !valid && !busy) else $error("active after reset");
endmodule

bind colormap_piecewise_linear cmpl_checker u_cmpl_checker (
  .clk(clk), .rst(rst), .busy(busy), .valid(valid),
  .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
);

// ----- verif/colormap_piecewise_linear_tb.sv -----
// ----------------------------------------------------------------------------
// colormap_piecewise_linear_tb
// self-checking bench: directed and random clear, insert, sample and unused-code beats,
// predicted colours compared field by field with every strobed result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module colormap_piecewise_linear_tb;
  import cmpl_pkg::*;

  typedef struct packed {
    opcode_t            op;
    logic [16:0]        t;
    logic signed [31:0] pos;
    logic signed [17:0] r;
    logic signed [17:0] g;
    logic signed [17:0] b;
  } beat_t;

  typedef struct packed {
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
  } colour_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = OP_NONE;
  logic [16:0] sample_t = '0;
  logic signed [31:0] point_position = '0;
  logic signed [17:0] point_red = '0, point_green = '0, point_blue = '0;
  logic valid;
  logic [16:0] out_red, out_green, out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  colormap_piecewise_linear u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .sample_t(sample_t), .point_position(point_position), .point_red(point_red),
    .point_green(point_green), .point_blue(point_blue), .valid(valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t   pending_beats[$];
  colour_t expected_colours[$];
  int errors = 0;
  int samples_seen = 0;
  int inserts_taken = 0;
  int gap_left = 0;

  // predictor copy of the table
  logic signed [63:0] tab_pos[MaxPoints];
  logic signed [63:0] tab_r[MaxPoints], tab_g[MaxPoints], tab_b[MaxPoints];
  int  tab_count = 0;
  logic rev_mode = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic queue_beat(input beat_t bt);
    pending_beats = {pending_beats, bt};
  endtask

  function automatic logic [16:0] blend_channel(longint c1, longint c2, longint frac);
    longint v;
    v = c1 * 65536 + frac * (c2 - c1);
    if (v <= 0) return 17'd0;
    if (v >= 64'sd4294967296) return 17'd65536;
    return 17'(v >>> 16);
  endfunction

  function automatic logic [16:0] clamp_channel(longint c);
    if (c < 0) return 17'd0;
    if (c > 65536) return 17'd65536;
    return 17'(c);
  endfunction

  task automatic predict_beat(input beat_t bt);
    int k, i;
    longint t, lo, hi, mapped, num, den, frac;
    colour_t c;
    case (bt.op)
      OP_CLEAR: tab_count = 0;
      OP_INSERT: begin
        if (tab_count < MaxPoints) begin
          k = tab_count;
          while (k > 0 && tab_pos[k-1] > bt.pos) begin
            tab_pos[k] = tab_pos[k-1];
            tab_r[k] = tab_r[k-1];
            tab_g[k] = tab_g[k-1];
            tab_b[k] = tab_b[k-1];
            k--;
          end
          tab_pos[k] = bt.pos;
          tab_r[k] = bt.r;
          tab_g[k] = bt.g;
          tab_b[k] = bt.b;
          tab_count++;
        end
      end
      OP_SAMPLE: begin
        t = bt.t;
        if (t > 65536) t = 65536;
        if (rev_mode) t = 65536 - t;
        if (tab_count == 0) begin
          c = '0;
        end else if (tab_count == 1) begin
          c.r = clamp_channel(tab_r[0]);
          c.g = clamp_channel(tab_g[0]);
          c.b = clamp_channel(tab_b[0]);
        end else begin
          lo = tab_pos[0];
          hi = tab_pos[tab_count-1];
          mapped = lo + (((hi - lo) * t) >>> 16);
          for (i = 0; i + 1 < tab_count; i++)
            if (mapped <= tab_pos[i+1]) break;
          if (i + 1 >= tab_count) i = tab_count - 2;
          den = tab_pos[i+1] - tab_pos[i];
          num = mapped - tab_pos[i];
          frac = 0;
          if (den > 0) begin
            if (num < 0) num = 0;
            frac = (num * 65536) / den;
            if (frac > 65536) frac = 65536;
          end
          c.r = blend_channel(tab_r[i], tab_r[i+1], frac);
          c.g = blend_channel(tab_g[i], tab_g[i+1], frac);
          c.b = blend_channel(tab_b[i], tab_b[i+1], frac);
        end
        expected_colours = {expected_colours, c};
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_beat({opcode_t'(opcode), sample_t, point_position,
                    point_red, point_green, point_blue});
      if (opcode == OP_INSERT) inserts_taken++;
      if (pending_beats.size() > 0 && $urandom_range(0, 3) != 0) begin
        beat_t bt;
        bt = pending_beats.pop_front();
        opcode <= bt.op; sample_t <= bt.t; point_position <= bt.pos;
        point_red <= bt.r; point_green <= bt.g; point_blue <= bt.b;
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() > 0) begin
        beat_t bt;
        bt = pending_beats.pop_front();
        start <= 1'b1;
        opcode <= bt.op; sample_t <= bt.t; point_position <= bt.pos;
        point_red <= bt.r; point_green <= bt.g; point_blue <= bt.b;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && valid) begin
      colour_t want;
      samples_seen++;
      if (expected_colours.size() == 0) begin
        report("unexpected result beat", samples_seen, 0);
      end else begin
        want = expected_colours.pop_front();
        if (out_red !== want.r) report("red", out_red, want.r);
        if (out_green !== want.g) report("green", out_green, want.g);
        if (out_blue !== want.b) report("blue", out_blue, want.b);
      end
    end
  end

  function automatic logic signed [17:0] rand_colour();
    case ($urandom_range(0, 5))
      0: return 18'sh20000;
      1: return 18'sh1ffff;
      2: return 18'sd0;
      3: return 18'sd65536;
      default: return 18'($urandom_range(0, 90000)) - 18'sd10000;
    endcase
  endfunction

  function automatic beat_t make_beat(opcode_t op);
    beat_t bt;
    bt.op = op;
    bt.t = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    case ($urandom_range(0, 4))
      0: bt.pos = $urandom;
      1: bt.pos = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: bt.pos = 32'($urandom_range(0, 8)) <<< 14;
    endcase
    bt.r = rand_colour();
    bt.g = rand_colour();
    bt.b = rand_colour();
    return bt;
  endfunction

  task automatic drain_then_config(input logic val);
    wait (pending_beats.size() == 0 && !start && expected_colours.size() == 0);
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rev_mode = val;
  endtask

  initial begin
    beat_t bt;
    int n, j;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: empty, single point, equal positions, extremes, unused code
    queue_beat(make_beat(OP_SAMPLE));
    bt = make_beat(OP_INSERT); bt.pos = 32'sh80000000; bt.r = 18'sh20000;
    bt.g = 18'sh1ffff; bt.b = 18'sd30000; queue_beat(bt);
    bt = make_beat(OP_SAMPLE); bt.t = 17'h1ffff; queue_beat(bt);
    bt = make_beat(OP_NONE); queue_beat(bt);
    bt = make_beat(OP_INSERT); bt.pos = 32'sh7fffffff; queue_beat(bt);
    bt = make_beat(OP_INSERT); bt.pos = 32'sh7fffffff; queue_beat(bt);
    bt = make_beat(OP_INSERT); bt.pos = 32'sd0; queue_beat(bt);
    bt = make_beat(OP_SAMPLE); bt.t = 17'd0; queue_beat(bt);
    bt.t = 17'd65536; queue_beat(bt);
    bt.t = 17'd32768; queue_beat(bt);
    bt.t = 17'd65535; queue_beat(bt);
    for (j = 0; j < 16; j++) begin
      bt = make_beat(OP_INSERT); queue_beat(bt);
    end
    bt = make_beat(OP_SAMPLE); queue_beat(bt);
    queue_beat(make_beat(OP_CLEAR));
    drain_then_config(1'b1);
    // random: clears, table builds with random content and samples
    for (n = 0; n < 1550; ) begin
      if ($urandom_range(0, 3) == 0)
        queue_beat(make_beat(OP_CLEAR));
      for (j = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 18 : 6); j > 0; j--) begin
        queue_beat(make_beat(OP_INSERT)); n++;
      end
      for (j = $urandom_range(1, 8); j > 0; j--) begin
        queue_beat(make_beat(($urandom_range(0, 15) == 0) ? OP_NONE : OP_SAMPLE));
        n++;
      end
      if ($urandom_range(0, 40) == 0) drain_then_config(1'($urandom_range(0, 1)));
      else wait (pending_beats.size() < 8);
    end
    drain_then_config(1'b0);
    queue_beat(make_beat(OP_SAMPLE));
    wait (pending_beats.size() == 0 && !start && expected_colours.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d inserts and %0d sampled colours, both reverse settings",
             inserts_taken, samples_seen);
    if (errors == 0 && expected_colours.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
